### src/rmf_pkg.sv
package rmf_pkg;

  // sample and result width
  localparam int SAMPLE_W = 24;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // item actions
  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN
  } state_t;

endpackage

### src/rmf_in_if.sv
interface rmf_in_if import rmf_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    action;
  sample_t sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink   (input valid, input action, input sample, output ready);
endinterface

### src/rmf_out_if.sv
interface rmf_out_if import rmf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

### src/running_median_filter.sv
// Running median over the last WINDOW signed 24-bit samples. A push beat stores
// its sample (the oldest one drops out once the window is full) and yields one
// median beat: the element at rank count/2 of the held samples, which is the
// upper median while the window is still filling. A clear beat empties the
// window and yields nothing. A push is ranked by a single shared
// signed comparator that takes one candidate per pass and tests it against the
// other held samples one per cycle unless a stalled output holds the last step;
// a push with n held samples takes a load step and at most n passes before the
// block is ready again. The input is not ready meanwhile; a finished median
// waits in the output register while the next beat is taken.
module running_median_filter import rmf_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  logic      clk,
  input  logic      rst,
  rmf_in_if.sink    samples,
  rmf_out_if.source medians
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int IW = $clog2(WINDOW);

  state_t state, state_next;

  sample_t         store [WINDOW];
  logic [CW-1:0]   fill;
  sample_t         work [WINDOW];
  sample_t         cand;
  logic [CW-1:0]   n;
  logic [IW-1:0]   t;
  logic [IW-1:0]   i;
  logic [IW-1:0]   cnt;
  logic            out_valid;
  sample_t         out_median;

  logic            in_acc;
  logic            push_acc;
  logic            clear_acc;
  logic            lt;
  logic [IW-1:0]   rank;
  logic            last;
  logic            found;
  sample_t         hit_val;
  logic            stall;
  logic            adv;
  logic            rotate;

  // handshake
  assign samples.ready  = (state == ST_IDLE);
  assign in_acc         = samples.valid && samples.ready;
  assign push_acc       = in_acc && (samples.action == ACT_PUSH);
  assign clear_acc      = in_acc && (samples.action == ACT_CLEAR);
  assign medians.valid  = out_valid;
  assign medians.median = out_median;

  // shared compare step: ties ordered by original entry index
  always_comb begin
    lt = 1'b0;
    if (t != '0) begin
      lt = (work[0] < cand) ||
           ((work[0] == cand) && (CW'(t) >= (n - CW'(i))));
    end
    rank    = cnt + IW'(lt);
    last    = (CW'(t) == (n - CW'(1)));
    found   = last && (CW'(rank) == (n >> 1));
    hit_val = (t == '0) ? work[0] : cand;
    stall   = found && out_valid && !medians.ready;
    adv     = (state == ST_RUN) && !stall;
    rotate  = adv && !last;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (push_acc) state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_RUN;
      ST_RUN: begin
        if (adv && found) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst || clear_acc) begin
      fill <= '0;
    end else if (push_acc && (fill != CW'(WINDOW))) begin
      fill <= fill + CW'(1);
    end
  end

  // window store and working copy, one entry each
  for (genvar k = 0; k < WINDOW; k++) begin : g_entry
    if (k < WINDOW - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (push_acc) begin
          if (fill == CW'(WINDOW))  store[k] <= store[k+1];
          else if (fill == CW'(k))  store[k] <= samples.sample;
        end
      end
      always_ff @(posedge clk) begin
        if (state == ST_LOAD) begin
          work[k] <= store[k];
        end else if (rotate) begin
          if (CW'(k) < (n - CW'(1)))       work[k] <= work[k+1];
          else if (CW'(k) == (n - CW'(1))) work[k] <= work[0];
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (push_acc && (fill >= CW'(WINDOW - 1))) begin
          store[k] <= samples.sample;
        end
      end
      always_ff @(posedge clk) begin
        if (state == ST_LOAD) begin
          work[k] <= store[k];
        end else if (rotate && (n == CW'(WINDOW))) begin
          work[k] <= work[0];
        end
      end
    end
  end

  // pass and step counters
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      n   <= fill;
      t   <= '0;
      i   <= '0;
      cnt <= '0;
    end else if (adv) begin
      if (t == '0) cand <= work[0];
      if (last) begin
        t   <= '0;
        cnt <= '0;
        i   <= (i == '0) ? IW'(n - CW'(1)) : i - IW'(1);
      end else begin
        t   <= t + IW'(1);
        cnt <= rank;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && found) begin
      out_valid <= 1'b1;
    end else if (medians.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && found) out_median <= hit_val;
  end

endmodule

### src/rmf_checker.sv
module rmf_checker import rmf_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    in_action,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t out_median
);

  logic push_beat;
  logic clear_beat;

  assign push_beat  = in_valid && in_ready && (in_action == ACT_PUSH);
  assign clear_beat = in_valid && in_ready && (in_action == ACT_CLEAR);

  // a stalled median beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_median))
    else $error("median beat changed while stalled");

  // a push keeps the input busy while it is ranked
  a_push_busy: assert property (@(posedge clk) disable iff (rst)
    push_beat |=> !in_ready)
    else $error("input ready right after a push");

  // the input is ready again in the cycle after a clear
  a_clear_fast: assert property (@(posedge clk) disable iff (rst)
    clear_beat |=> in_ready)
    else $error("input not ready after a clear");

  // no median can appear in the load cycle of a push
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    push_beat |=> !$rose(out_valid))
    else $error("median beat too early after a push");

  // reset leaves no median pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("median beat pending after reset");

endmodule

bind running_median_filter rmf_checker u_rmf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .in_action  (samples.action),
  .out_valid  (medians.valid),
  .out_ready  (medians.ready),
  .out_median (medians.median)
);

### sim/running_median_filter_test.sv
module running_median_filter_test import rmf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW          = 5;
  localparam int RANDOM_PER_PHASE = 275;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_OFF_CYCLES = 400;

  localparam sample_t S_MAX = 24'sh7FFFFF;
  localparam sample_t S_MIN = 24'sh800000;

  // one row of the directed table; known marks a median typed in by hand
  typedef struct packed {
    logic    action;
    sample_t sample;
    logic    known;
    sample_t median;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 22;

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ACT_PUSH,  S_MAX,         1'b1, S_MAX},
    '{ACT_PUSH,  S_MIN,         1'b1, S_MAX},
    '{ACT_PUSH,  24'sh000000,   1'b0, '0},
    '{ACT_PUSH,  24'shFFFFFF,   1'b0, '0},
    '{ACT_PUSH,  24'sh000001,   1'b0, '0},
    '{ACT_PUSH,  S_MAX,         1'b0, '0},
    '{ACT_PUSH,  S_MIN,         1'b0, '0},
    '{ACT_CLEAR, 24'sh5A5A5A,   1'b0, '0},
    '{ACT_PUSH,  S_MIN,         1'b1, S_MIN},
    '{ACT_CLEAR, '0,            1'b0, '0},
    '{ACT_CLEAR, S_MAX,         1'b0, '0},
    '{ACT_PUSH,  24'sh000000,   1'b1, 24'sh000000},
    '{ACT_PUSH,  24'sh555555,   1'b0, '0},
    '{ACT_PUSH,  24'shAAAAAA,   1'b0, '0},
    '{ACT_CLEAR, '0,            1'b0, '0},
    '{ACT_PUSH,  24'sh000007,   1'b1, 24'sh000007},
    '{ACT_PUSH,  24'sh000007,   1'b1, 24'sh000007},
    '{ACT_PUSH,  24'sh000007,   1'b1, 24'sh000007},
    '{ACT_PUSH,  24'sh000007,   1'b1, 24'sh000007},
    '{ACT_PUSH,  24'sh000007,   1'b1, 24'sh000007},
    '{ACT_PUSH,  24'sh000007,   1'b1, 24'sh000007},
    '{ACT_PUSH,  24'shFFFFF9,   1'b0, '0}
  };

  logic clk;
  logic rst;

  rmf_in_if  samples_if ();
  rmf_out_if medians_if ();

  running_median_filter #(.WINDOW(WINDOW)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .medians (medians_if)
  );

  // shadow copy of the window
  sample_t     held [WINDOW];
  int unsigned held_count;
  int unsigned write_pos;

  sample_t medians_due [$];
  int      fail_count;
  int      cycle_count;
  int      src_idle_pct;
  int      snk_stall_pct;
  logic    hold_off;
  sample_t last_sample;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reset
  initial begin
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic void report_error(string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < WINDOW; i++) held[i] = '0;
    held_count = 0;
    write_pos  = 0;
  endfunction

  // store a sample and rank the held ones, upper median while filling
  function automatic sample_t push_and_rank(sample_t smp);
    sample_t ranked [WINDOW];
    sample_t key;
    int      j;
    held[write_pos] = smp;
    write_pos = (write_pos + 1) % WINDOW;
    if (held_count < WINDOW) held_count++;
    for (int i = 0; i < WINDOW; i++) ranked[i] = held[i];
    for (int i = 1; i < held_count; i++) begin
      key = ranked[i];
      j   = i;
      while (j > 0 && ranked[j-1] > key) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = key;
    end
    return ranked[held_count / 2];
  endfunction

  // offer one beat, keep valid up if the next one follows directly
  task automatic send_beat(input logic act, input sample_t smp, input logic known,
                           input sample_t typed_median);
    sample_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      samples_if.valid <= 1'b0;
      @(posedge clk);
    end
    samples_if.valid  <= 1'b1;
    samples_if.action <= act;
    samples_if.sample <= smp;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    if (act == ACT_CLEAR) begin
      clear_window();
    end else begin
      predicted = push_and_rank(smp);
      medians_due.push_back(known ? typed_median : predicted);
    end
  endtask

  // mix of extremes, near-zero values, repeats, shifted small values and full-range noise
  function automatic sample_t pick_sample();
    sample_t smp;
    case ($urandom_range(9))
      0:       smp = S_MAX;
      1:       smp = S_MIN;
      2:       smp = sample_t'($urandom_range(6)) - sample_t'(3);
      3:       smp = last_sample;
      4:       smp = sample_t'($urandom_range(15)) << $urandom_range(20);
      default: smp = sample_t'($urandom());
    endcase
    last_sample = smp;
    return smp;
  endfunction

  task automatic hold_off_stretch();
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  // result side: check accepted beats, then choose next ready
  initial begin
    sample_t want;
    medians_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && medians_if.valid && medians_if.ready) begin
        if (medians_due.size() == 0) begin
          report_error($sformatf("unexpected median %0d", medians_if.median));
        end else begin
          want = medians_due.pop_front();
          if (medians_if.median !== want)
            report_error($sformatf("median expected %0d got %0d", want, medians_if.median));
        end
      end
      medians_if.ready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // stimulus
  initial begin
    int phase_idle [4];
    int phase_stall [4];
    int drain;
    samples_if.valid  <= 1'b0;
    samples_if.action <= ACT_PUSH;
    samples_if.sample <= '0;
    fail_count    = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_off      = 1'b0;
    last_sample   = '0;
    clear_window();
    phase_idle  = '{0, 76, 0, 22};
    phase_stall = '{0, 0, 76, 22};

    @(negedge rst);
    @(posedge clk);

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_beat(DIRECTED[r].action, DIRECTED[r].sample, DIRECTED[r].known,
                DIRECTED[r].median);

    // random phases with different idling
    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = phase_idle[p];
      snk_stall_pct = phase_stall[p];
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        // long receiver hold-off while the sender keeps offering
        if (p == 0 && i == 100) fork hold_off_stretch(); join_none
        if ($urandom_range(29) == 0)
          send_beat(ACT_CLEAR, sample_t'($urandom()), 1'b0, '0);
        else
          send_beat(ACT_PUSH, pick_sample(), 1'b0, '0);
      end
    end
    samples_if.valid <= 1'b0;

    // drain and settle
    drain = 0;
    while (medians_due.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (medians_due.size() != 0)
      report_error($sformatf("%0d medians never arrived", medians_due.size()));

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/rmf_pkg.sv
src/rmf_in_if.sv
src/rmf_out_if.sv
src/running_median_filter.sv
src/rmf_checker.sv
sim/running_median_filter_test.sv
